// ===== sv/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg: shared types and constants for the LZ77 stream decompressor.
// Holds the result item layout and the fixed token field constants.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  // Width of one stream byte.
  localparam int unsigned BYTE_W = 8;

  // Width of the declared decompressed size in the header.
  localparam int unsigned SIZE_W = 24;

  // Number of header bytes (type byte plus three size bytes).
  localparam logic [2:0] HDR_BYTES = 3'd4;

  // Header byte positions of the size field, least significant first.
  localparam logic [2:0] HDR_SIZE0 = 3'd1;
  localparam logic [2:0] HDR_SIZE1 = 3'd2;
  localparam logic [2:0] HDR_SIZE2 = 3'd3;

  // Tokens described by one flag byte.
  localparam logic [3:0] FLAG_TOKENS = 4'd8;

  // Minimum match length added to the length nibble.
  localparam logic [4:0] MATCH_MIN_LEN = 5'd3;

  // One result item as it travels to the output channel.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_end;
  } out_item_t;

endpackage

// ===== sv/lzsd_ram.sv =====
// ----------------------------------------------------------------------------
// lzsd_ram: generic simple dual-port RAM.
// One write port and one read port; the read data is registered and holds
// its value until the next read is enabled.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/lzsd_obuf.sv =====
// ----------------------------------------------------------------------------
// lzsd_obuf: two-entry output buffer.
// Decouples the decoder from the output channel so that a waiting result
// does not hold up the next request on the input side.
// ----------------------------------------------------------------------------
module lzsd_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lzsd_pkg::out_item_t   push_item,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lzsd_pkg::out_item_t   out_item
);

  logic [1:0]          count_r;
  logic [1:0]          count_nxt;
  lzsd_pkg::out_item_t head_r;
  lzsd_pkg::out_item_t tail_r;
  logic                pop;
  logic [1:0]          count_after_pop;

  // Handshake on the output side and free-space indication.
  assign out_valid       = (count_r != 2'd0);
  assign out_item        = head_r;
  assign space           = (count_r != 2'd2);
  assign pop             = out_valid && out_ready;
  assign count_after_pop = count_r - {1'b0, pop};
  assign count_nxt       = count_after_pop + {1'b0, push};

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entry storage: a pop moves the tail forward, a push fills the first free slot.
  always_ff @(posedge clk) begin
    if (push && (count_after_pop == 2'd0)) begin
      head_r <= push_item;
    end else if (pop) begin
      head_r <= tail_r;
    end
    if (push && (count_after_pop != 2'd0)) begin
      tail_r <= push_item;
    end
  end

endmodule

// ===== sv/lz77_stream_decompressor.sv =====
// ----------------------------------------------------------------------------
// Channel | Direction | tdata            | tuser        | tlast
// in_     | input     | [7:0] in_byte    | new_stream   | -
// out_    | output    | [7:0] out_byte   | stream_end   | last_of_run
//
// Header, flag, first-match and literal bytes are each handled on acceptance.
// A match sets up the copy on its second byte, then copies each byte by a
// history read, then a history write and emit, as set by the single
// history RAM's registered read.
// Reset is synchronous; after reset the block drops bytes until new_stream.
// A stalled output pauses the copy; the input waits while a match copies.
// ----------------------------------------------------------------------------
// lz77_stream_decompressor: LZ77 decoder with a 4096-byte history window.
// Parses the size header and flag-driven tokens, emits literals and
// copies matches byte by byte through the history memory.
// ----------------------------------------------------------------------------
module lz77_stream_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] new_stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] stream_end
  output logic       out_tlast
);

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [2:0]                      hdr_idx_r, hdr_idx_nxt;
  logic [lzsd_pkg::SIZE_W-1:0]     rem_r, rem_nxt;
  logic [7:0]                      flags_r, flags_nxt;
  logic [3:0]                      flags_left_r, flags_left_nxt;
  logic                            pend_r, pend_nxt;
  logic [7:0]                      first_r, first_nxt;
  logic [PTR_W-1:0]                ptr_r, ptr_nxt;
  logic [PTR_W-1:0]                src_r, src_nxt;
  logic [4:0]                      cnt_r, cnt_nxt;
  logic                            fin_r, fin_nxt;

  logic                            ob_space;
  logic                            push;
  lzsd_pkg::out_item_t             push_item;
  lzsd_pkg::out_item_t             ob_item;
  logic                            wr_en;
  logic [7:0]                      wr_data;
  logic                            rd_en;
  logic [7:0]                      rd_data;
  logic                            acc;
  logic                            copy_end;
  logic                            copy_last;
  logic [11:0]                     match_off;

  // History memory.
  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ptr_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (src_r),
    .rd_data (rd_data)
  );

  // Output buffer.
  lzsd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .space     (ob_space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (ob_item)
  );

  assign out_tdata = ob_item.out_byte;
  assign out_tlast = ob_item.last_of_run;
  assign out_tuser = ob_item.stream_end;

  // Input requests are taken only between matches and with buffer room.
  assign in_tready = (state_r == ST_IDLE) && ob_space;
  assign acc       = in_tvalid && in_tready;

  // Copy termination: size reached or match length used up.
  assign copy_end  = (rem_r == lzsd_pkg::SIZE_W'(1));
  assign copy_last = copy_end || (cnt_r == 5'd1);
  assign match_off = {first_r[3:0], in_tdata};

  // Token decoding and copy sequencing.
  always_comb begin
    state_nxt      = state_r;
    hdr_idx_nxt    = hdr_idx_r;
    rem_nxt        = rem_r;
    flags_nxt      = flags_r;
    flags_left_nxt = flags_left_r;
    pend_nxt       = pend_r;
    first_nxt      = first_r;
    ptr_nxt        = ptr_r;
    src_nxt        = src_r;
    cnt_nxt        = cnt_r;
    fin_nxt        = fin_r;
    wr_en          = 1'b0;
    wr_data        = in_tdata;
    rd_en          = 1'b0;
    push           = 1'b0;
    push_item      = '{out_byte: in_tdata, last_of_run: 1'b1, stream_end: copy_end};

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_tuser) begin
            // Restart: this byte is the ignored type byte.
            hdr_idx_nxt    = 3'd1;
            rem_nxt        = '0;
            flags_nxt      = '0;
            flags_left_nxt = '0;
            pend_nxt       = 1'b0;
            ptr_nxt        = '0;
            fin_nxt        = 1'b0;
          end else if (!fin_r) begin
            priority if (hdr_idx_r < lzsd_pkg::HDR_BYTES) begin
              // Header bytes collect the size, least significant first.
              if (hdr_idx_r == lzsd_pkg::HDR_SIZE0) begin
                rem_nxt[7:0] = in_tdata;
              end
              if (hdr_idx_r == lzsd_pkg::HDR_SIZE1) begin
                rem_nxt[15:8] = in_tdata;
              end
              if (hdr_idx_r == lzsd_pkg::HDR_SIZE2) begin
                rem_nxt[23:16] = in_tdata;
                fin_nxt        = ({in_tdata, rem_r[15:0]} == '0);
              end
              hdr_idx_nxt = hdr_idx_r + 3'd1;
            end else if (pend_r) begin
              // Second match byte: set up the copy source and length.
              pend_nxt  = 1'b0;
              src_nxt   = ptr_r + PTR_W'(~match_off);
              cnt_nxt   = {1'b0, first_r[7:4]} + lzsd_pkg::MATCH_MIN_LEN;
              state_nxt = ST_READ;
            end else if (flags_left_r == 4'd0) begin
              flags_nxt      = in_tdata;
              flags_left_nxt = lzsd_pkg::FLAG_TOKENS;
            end else begin
              flags_nxt      = {flags_r[6:0], 1'b0};
              flags_left_nxt = flags_left_r - 4'd1;
              if (flags_r[7]) begin
                first_nxt = in_tdata;
                pend_nxt  = 1'b1;
              end else begin
                // Literal: store in history and emit.
                wr_en   = 1'b1;
                push    = 1'b1;
                ptr_nxt = ptr_r + PTR_W'(1);
                rem_nxt = rem_r - lzsd_pkg::SIZE_W'(1);
                if (copy_end) begin
                  fin_nxt = 1'b1;
                end
              end
            end
          end
        end
      end

      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_WRITE;
      end

      ST_WRITE: begin
        // Copy one history byte once the output buffer has room.
        wr_data   = rd_data;
        push_item = '{out_byte: rd_data, last_of_run: copy_last, stream_end: copy_end};
        if (ob_space) begin
          wr_en     = 1'b1;
          push      = 1'b1;
          ptr_nxt   = ptr_r + PTR_W'(1);
          src_nxt   = src_r + PTR_W'(1);
          rem_nxt   = rem_r - lzsd_pkg::SIZE_W'(1);
          cnt_nxt   = cnt_r - 5'd1;
          if (copy_end) begin
            fin_nxt = 1'b1;
          end
          state_nxt = copy_last ? ST_IDLE : ST_READ;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hdr_idx_r    <= '0;
      rem_r        <= '0;
      flags_r      <= '0;
      flags_left_r <= '0;
      pend_r       <= 1'b0;
      first_r      <= '0;
      ptr_r        <= '0;
      src_r        <= '0;
      cnt_r        <= '0;
      fin_r        <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      rem_r        <= rem_nxt;
      flags_r      <= flags_nxt;
      flags_left_r <= flags_left_nxt;
      pend_r       <= pend_nxt;
      first_r      <= first_nxt;
      ptr_r        <= ptr_nxt;
      src_r        <= src_nxt;
      cnt_r        <= cnt_nxt;
      fin_r        <= fin_nxt;
    end
  end

endmodule

// ===== tb/lz77_stream_decompressor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz77_stream_decompressor_tb: self-checking testbench for the LZ77 decoder.
// Feeds compressed streams with random idle cycles and output stalls. A
// model of the decoder predicts every decompressed byte, and each result is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module lz77_stream_decompressor_tb;

  localparam int unsigned WINDOW         = 4096;
  localparam int unsigned MAX_GAP        = 10;
  localparam int unsigned STALL_HOLD     = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned RANDOM_ITEMS   = 320;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tuser   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  // Decoder model state.
  logic [2:0]                  hdr_pos    = '0;
  logic [lzsd_pkg::SIZE_W-1:0] size_left  = '0;
  logic [7:0]                  flag_reg   = '0;
  logic [3:0]                  flag_cnt   = '0;
  logic                        match_wait = 1'b0;
  logic [7:0]                  match_head = '0;
  logic [11:0]                 wr_ptr     = '0;
  logic                        stream_done = 1'b1;
  logic [7:0]                  window_mem [WINDOW];
  bit                          window_ok  [WINDOW];
  int unsigned                 window_fill = 0;

  // Decompressed bytes still to come out of the block.
  lzsd_pkg::out_item_t decoded_q [$];

  // Run control and statistics.
  bit          steady      = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_fed    = 0;
  int unsigned streams_started = 0;
  int unsigned results_seen = 0;
  int unsigned tokens_sent  = 0;
  int unsigned mismatches   = 0;

  lz77_stream_decompressor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Writes one decoded byte into the window; returns 1 when the size is complete.
  function automatic bit store_decoded(input logic [7:0] value);
    window_mem[wr_ptr] = value;
    if (!window_ok[wr_ptr]) begin
      window_ok[wr_ptr] = 1'b1;
      window_fill++;
    end
    wr_ptr = wr_ptr + 12'd1;
    size_left = size_left - 1'b1;
    if (size_left == '0) stream_done = 1'b1;
    return size_left == '0;
  endfunction

  // Number of written window entries directly behind the write pointer.
  function automatic int unsigned window_reach();
    int unsigned n;
    logic [11:0] idx;
    if (window_fill == WINDOW) return WINDOW;
    n = 0;
    idx = wr_ptr - 12'd1;
    while (n < WINDOW && window_ok[idx]) begin
      n++;
      idx = idx - 12'd1;
    end
    return n;
  endfunction

  // Decodes one accepted request and queues the bytes it produces.
  task automatic decode_byte(input logic [7:0] b, input logic restart);
    lzsd_pkg::out_item_t run [$];
    lzsd_pkg::out_item_t item;
    logic [4:0] len;
    logic [12:0] match_dist;
    logic [11:0] src;
    bit ends;
    if (restart) begin
      hdr_pos = '0;
      size_left = '0;
      flag_reg = '0;
      flag_cnt = '0;
      match_wait = 1'b0;
      match_head = '0;
      wr_ptr = '0;
      stream_done = 1'b0;
    end
    if (!stream_done) begin
      if (hdr_pos < lzsd_pkg::HDR_BYTES) begin
        // Header: type byte, then the size least significant byte first.
        case (hdr_pos)
          lzsd_pkg::HDR_SIZE0: size_left[7:0] = b;
          lzsd_pkg::HDR_SIZE1: size_left[15:8] = b;
          lzsd_pkg::HDR_SIZE2: size_left[23:16] = b;
          default: ;
        endcase
        hdr_pos++;
        if (hdr_pos == lzsd_pkg::HDR_BYTES && size_left == '0) stream_done = 1'b1;
      end else if (match_wait) begin
        // Second match byte: copy from the window, stopping at the declared size.
        match_wait = 1'b0;
        len = {1'b0, match_head[7:4]} + lzsd_pkg::MATCH_MIN_LEN;
        match_dist = {1'b0, match_head[3:0], b} + 13'd1;
        ends = 1'b0;
        for (int j = 0; j < len && !ends; j++) begin
          src = wr_ptr - match_dist[11:0];
          item.out_byte = window_mem[src];
          ends = store_decoded(item.out_byte);
          item.last_of_run = 1'b0;
          item.stream_end = ends;
          run.push_back(item);
        end
      end else if (flag_cnt == '0) begin
        flag_reg = b;
        flag_cnt = lzsd_pkg::FLAG_TOKENS;
      end else begin
        flag_cnt--;
        if (flag_reg[7]) begin
          match_head = b;
          match_wait = 1'b1;
        end else begin
          item.out_byte = b;
          item.last_of_run = 1'b0;
          item.stream_end = store_decoded(b);
          run.push_back(item);
        end
        flag_reg = flag_reg << 1;
      end
    end
    foreach (run[k]) begin
      item = run[k];
      item.last_of_run = (k == run.size() - 1);
      decoded_q.push_back(item);
    end
  endtask

  // Offers one request after a random gap and returns at the next falling edge.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= restart;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Sends one well-formed stream with random tokens; cut_after > 0 abandons it early.
  task automatic run_stream(input int unsigned size, input int unsigned match_pct,
                            input bit long_runs, input int unsigned cut_after);
    logic [7:0] head [4];
    logic [7:0] flags;
    logic [3:0] len_code;
    logic [11:0] dist_code;
    int unsigned reach;
    int unsigned sent;
    head[0] = 8'($urandom_range(0, 255));
    head[1] = size[7:0];
    head[2] = size[15:8];
    head[3] = size[23:16];
    sent = 0;
    dist_code = '0;
    for (int h = 0; h < int'(lzsd_pkg::HDR_BYTES) && (cut_after == 0 || sent < cut_after);
         h++) begin
      send_byte(head[h], h == 0);
      sent++;
    end
    // The model tells which token comes next, so every byte lands where intended.
    while (!stream_done && (cut_after == 0 || sent < cut_after)) begin
      if (match_wait) begin
        send_byte(dist_code[7:0], 1'b0);
      end else if (flag_cnt == '0) begin
        for (int k = 0; k < 8; k++) flags[k] = ($urandom_range(1, 100) <= match_pct);
        // Nothing behind the pointer yet: the first token has to be a literal.
        if (window_reach() == 0) flags[7] = 1'b0;
        send_byte(flags, 1'b0);
      end else if (flag_reg[7]) begin
        reach = window_reach();
        case ($urandom_range(0, 3))
          0: dist_code = '0;
          1: dist_code = 12'(reach - 1);
          default: dist_code = 12'($urandom_range(0, reach - 1));
        endcase
        len_code = (long_runs && $urandom_range(0, 7) != 0) ? 4'hF
                                                           : 4'($urandom_range(0, 15));
        send_byte({len_code, dist_code[11:8]}, 1'b0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      sent++;
    end
    tokens_sent += sent;
  endtask

  // Bytes before any stream has started are dropped.
  task automatic test_ignored_before_stream();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // A zero size finishes the stream at the header; later bytes are dropped.
  task automatic test_zero_size_stream();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  // Two literals, then a maximum-length run at distance one that the size cuts short.
  task automatic test_literals_and_overlap();
    send_byte(8'h00, 1'b1);
    send_byte(8'd12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
  endtask

  // A new stream with the largest size reaches the full window back into the
  // previous stream, reading the entry that is about to be overwritten.
  task automatic test_full_distance_restart();
    send_byte(8'h10, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // The receiver holds off for a long stretch while literals keep coming.
  task automatic test_output_stall();
    steady = 1'b1;
    rx_hold_req = 1'b1;
    run_stream(48, 0, 1'b0, 0);
    in_tvalid <= 1'b0;
    while (rx_hold_req) @(negedge clk);
    steady = 1'b0;
  endtask

  // Many short streams, some empty, some abandoned, some followed by stray bytes.
  task automatic test_random_streams();
    int unsigned start;
    int unsigned size;
    int unsigned pick;
    int unsigned cut;
    start = tokens_sent;
    while (tokens_sent - start < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) size = 0;
      else if (pick < 4) size = $urandom_range(41, 200);
      else size = $urandom_range(1, 40);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 14) : 0;
      run_stream(size, $urandom_range(10, 70), $urandom_range(0, 3) == 0, cut);
      if (stream_done && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    steady = 1'b0;
  endtask

  // Result receiver: a random stall before each result, plus the long hold-off.
  initial begin : result_sink
    int unsigned wait_cycles;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (STALL_HOLD) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      wait_cycles = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Monitor: predicts on each accepted request, then checks each accepted result.
  always @(posedge clk) begin : monitor
    lzsd_pkg::out_item_t want;
    if (rst_n) begin
      quiet_cycles = quiet_cycles + 1;
      if (in_tvalid && in_tready) begin
        bytes_fed++;
        if (in_tuser) streams_started++;
        quiet_cycles = 0;
        decode_byte(in_tdata, in_tuser);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        quiet_cycles = 0;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: byte %h last %b end %b",
                     out_tdata, out_tlast, out_tuser);
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.out_byte || out_tlast !== want.last_of_run ||
              out_tuser !== want.stream_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: got byte %h last %b end %b, expected byte %h last %b end %b",
                       results_seen, out_tdata, out_tlast, out_tuser,
                       want.out_byte, want.last_of_run, want.stream_end);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout after %0d quiet cycles", quiet_cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_ignored_before_stream();
    test_zero_size_stream();
    test_literals_and_overlap();
    test_full_distance_restart();
    test_output_stall();
    test_random_streams();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Fed %0d bytes in %0d streams and checked %0d decompressed bytes.",
             bytes_fed, streams_started, results_seen);
    $display("Streams covered empty, cut and restarted cases, overlapping and %s",
             "full-window matches and a long output stall.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
